[rtl/randomized_prim_maze_generator_unit_assert.svh]
// Assertion macros used by the maze generator datapath.
`ifndef RANDOMIZED_PRIM_MAZE_GENERATOR_UNIT_ASSERT_SVH
`define RANDOMIZED_PRIM_MAZE_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RPMG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define RPMG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/rpmg_pkg.sv]
// Package with types, constants and codes of the maze generator.
`timescale 1ns / 1ps
package rpmg_pkg;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 7;
  localparam int CELL_AW    = COL_W + ROW_W;
  localparam int DIM_W      = 8;
  localparam int RND_W      = 31;
  localparam int LIST_DEPTH = 65536;
  localparam int LIST_AW    = 16;
  localparam int CNT_W      = 17;
  localparam int DIV_IT_W   = 5;
  localparam int CFG_IDX_W  = 1;

  localparam logic [DIM_W-1:0] MAX_COLS   = 8'd128;
  localparam logic [DIM_W-1:0] MAX_ROWS   = 8'd128;
  localparam logic [DIM_W-1:0] MIN_DIM    = 8'd5;
  localparam logic [DIM_W-1:0] RST_COLS   = 8'd80;
  localparam logic [DIM_W-1:0] RST_ROWS   = 8'd45;

  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd1;

  localparam logic [1:0] K_WALL  = 2'd0;
  localparam logic [1:0] K_PASS  = 2'd1;
  localparam logic [1:0] K_START = 2'd2;
  localparam logic [1:0] K_GOAL  = 2'd3;

  localparam logic [1:0] F_START = 2'd0;
  localparam logic [1:0] F_STEP  = 2'd1;
  localparam logic [1:0] F_READ  = 2'd2;

  localparam logic [2:0] ST_STARTED  = 3'd0;
  localparam logic [2:0] ST_STEPPED  = 3'd1;
  localparam logic [2:0] ST_FINISHED = 3'd2;
  localparam logic [2:0] ST_IGNORED  = 3'd3;
  localparam logic [2:0] ST_READ     = 3'd4;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_GEN  = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  typedef struct packed {
    logic [1:0]       func;
    logic [RND_W-1:0] random_word;
    logic [COL_W-1:0] read_col;
    logic [ROW_W-1:0] read_row;
  } in_req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [COL_W-1:0] pick_col;
    logic [ROW_W-1:0] pick_row;
    logic             opened;
    logic [CNT_W-1:0] pending_count;
    logic [1:0]       cell_kind;
    logic             finished;
  } out_rsp_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_CLR, OP_START_INIT, OP_SEED, OP_DIV_INIT, OP_DIV_STEP,
    OP_LIST_RD, OP_PICK, OP_SH_RD, OP_SH_WR, OP_NB_RD, OP_NB_CAP, OP_OPEN, OP_PUSH,
    OP_FIN_S, OP_FIN_G, OP_FIN_RL, OP_FIN_CL, OP_FIN_RU, OP_FIN_CU, OP_FIN_OPEN,
    OP_CELL_RD, OP_CELL_CAP, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] stat;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       clr_last;
    logic       div_last;
    logic       sh_more;
    logic       nb_last;
    logic       open_ok;
    logic       count_zero;
    logic       step_ok;
    logic       out_free;
  } dp_sts_t;
endpackage

[rtl/rpmg_datapath.sv]
// Datapath of the maze generator: grid and list memories, divider, output register.
`timescale 1ns / 1ps
`include "randomized_prim_maze_generator_unit_assert.svh"
module rpmg_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rpmg_pkg::dp_cmd_t             cmd,
  output rpmg_pkg::dp_sts_t             sts,
  input  rpmg_pkg::in_req_t             in_data,
  input  logic                          cfg_we,
  input  logic [rpmg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rpmg_pkg::DIM_W-1:0]    cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rpmg_pkg::out_rsp_t            out_data
);
  logic [1:0] grid_mem [0:(1 << rpmg_pkg::CELL_AW)-1];
  logic [rpmg_pkg::CELL_AW-1:0] list_mem [0:rpmg_pkg::LIST_DEPTH-1];

  logic [rpmg_pkg::DIM_W-1:0]   cols_cfg_r, rows_cfg_r, act_cols_r, act_rows_r;
  rpmg_pkg::in_req_t            req_r;
  logic [rpmg_pkg::CELL_AW-1:0] clr_addr_r;
  logic [rpmg_pkg::CNT_W-1:0]   rem_r, count_r;
  logic [rpmg_pkg::RND_W-1:0]   dvd_r;
  logic [rpmg_pkg::DIV_IT_W-1:0] it_r;
  logic [rpmg_pkg::LIST_AW-1:0] ptr_r;
  logic [rpmg_pkg::COL_W-1:0]   pc_r;
  logic [rpmg_pkg::ROW_W-1:0]   pr_r;
  logic                         opened_r;
  logic [1:0]                   kind_r, phase_r, nb_idx_r, g_rd_r;
  logic [3:0]                   pass_f_r, wall_f_r;
  logic                         left_wall_r, up_wall_r;
  logic [rpmg_pkg::CELL_AW-1:0] l_rd_r;
  logic                         out_valid_r;
  rpmg_pkg::out_rsp_t           out_data_r;

  logic                         g_we, g_re, l_we, l_re;
  logic [rpmg_pkg::CELL_AW-1:0] g_addr, l_wd, l_rd_addr_c;
  logic [1:0]                   g_wd;
  logic [rpmg_pkg::LIST_AW-1:0] l_waddr, l_raddr;
  logic [8:0]                   nb_c [0:3];
  logic [8:0]                   nb_r [0:3];
  logic [3:0]                   nb_in;
  logic [rpmg_pkg::CELL_AW-1:0] nb_addr [0:3];
  logic [rpmg_pkg::COL_W-1:0]   gc, pick_c;
  logic [rpmg_pkg::ROW_W-1:0]   gr, pick_r;
  logic [rpmg_pkg::CNT_W:0]     div_acc, div_d;
  logic                         out_free, list_room, read_in;

  function automatic logic [rpmg_pkg::DIM_W-1:0] clampv(input logic [rpmg_pkg::DIM_W-1:0] v,
                                                        input logic [rpmg_pkg::DIM_W-1:0] hi);
    logic [rpmg_pkg::DIM_W-1:0] res;
    res = v;
    if (v < rpmg_pkg::MIN_DIM) res = rpmg_pkg::MIN_DIM;
    else if (v > hi) res = hi;
    return res;
  endfunction

  function automatic logic interior(input logic [8:0] v, input logic [rpmg_pkg::DIM_W-1:0] n);
    return (v >= 9'd1) && ({1'b0, v} + 10'd2 <= {2'b00, n});
  endfunction

  always_comb begin
    nb_c[0] = {2'b00, pc_r} - 9'd1;  nb_r[0] = {2'b00, pr_r};
    nb_c[1] = {2'b00, pc_r} + 9'd1;  nb_r[1] = {2'b00, pr_r};
    nb_c[2] = {2'b00, pc_r};         nb_r[2] = {2'b00, pr_r} - 9'd1;
    nb_c[3] = {2'b00, pc_r};         nb_r[3] = {2'b00, pr_r} + 9'd1;
    for (int d = 0; d < 4; d++) begin
      nb_in[d]   = interior(nb_c[d], act_cols_r) && interior(nb_r[d], act_rows_r);
      nb_addr[d] = {nb_c[d][rpmg_pkg::COL_W-1:0], nb_r[d][rpmg_pkg::ROW_W-1:0]};
    end
  end

  assign gc = act_cols_r[rpmg_pkg::COL_W-1:0] - 7'd2;
  assign gr = act_rows_r[rpmg_pkg::ROW_W-1:0] - 7'd2;
  assign pick_c = ({1'b0, l_rd_r[rpmg_pkg::CELL_AW-1 -: rpmg_pkg::COL_W]} >= act_cols_r) ?
                  act_cols_r[rpmg_pkg::COL_W-1:0] - 7'd1 :
                  l_rd_r[rpmg_pkg::CELL_AW-1 -: rpmg_pkg::COL_W];
  assign pick_r = ({1'b0, l_rd_r[rpmg_pkg::ROW_W-1:0]} >= act_rows_r) ?
                  act_rows_r[rpmg_pkg::ROW_W-1:0] - 7'd1 : l_rd_r[rpmg_pkg::ROW_W-1:0];
  assign div_acc = {rem_r, dvd_r[rpmg_pkg::RND_W-1]};
  assign div_d = div_acc - {1'b0, count_r};
  assign list_room = count_r < rpmg_pkg::CNT_W'(rpmg_pkg::LIST_DEPTH);
  assign out_free = !out_valid_r || out_ready;
  assign read_in = ({1'b0, req_r.read_col} < act_cols_r) && ({1'b0, req_r.read_row} < act_rows_r);
  assign l_rd_addr_c = {nb_c[nb_idx_r][rpmg_pkg::COL_W-1:0], nb_r[nb_idx_r][rpmg_pkg::ROW_W-1:0]};

  always_comb begin
    g_we = 1'b0; g_re = 1'b0; g_addr = clr_addr_r; g_wd = rpmg_pkg::K_WALL;
    l_we = 1'b0; l_re = 1'b0; l_waddr = ptr_r; l_raddr = ptr_r; l_wd = l_rd_r;
    unique case (cmd.op)
      rpmg_pkg::OP_CLR: g_we = 1'b1;
      rpmg_pkg::OP_START_INIT: begin
        g_we = 1'b1; g_addr = {7'd1, 7'd1}; g_wd = rpmg_pkg::K_PASS;
        l_we = 1'b1; l_waddr = '0; l_wd = {7'd1, 7'd2};
      end
      rpmg_pkg::OP_SEED: begin
        l_we = 1'b1; l_waddr = 16'd1; l_wd = {7'd2, 7'd1};
      end
      rpmg_pkg::OP_LIST_RD: begin
        l_re = 1'b1; l_raddr = rem_r[rpmg_pkg::LIST_AW-1:0];
      end
      rpmg_pkg::OP_SH_RD: begin
        l_re = 1'b1; l_raddr = ptr_r + 16'd1;
      end
      rpmg_pkg::OP_SH_WR: l_we = 1'b1;
      rpmg_pkg::OP_NB_RD: begin
        g_re = 1'b1; g_addr = nb_addr[nb_idx_r];
      end
      rpmg_pkg::OP_OPEN: begin
        g_we = 1'b1; g_addr = {pc_r, pr_r}; g_wd = rpmg_pkg::K_PASS;
      end
      rpmg_pkg::OP_PUSH: begin
        l_we = wall_f_r[nb_idx_r] && list_room;
        l_waddr = count_r[rpmg_pkg::LIST_AW-1:0]; l_wd = l_rd_addr_c;
      end
      rpmg_pkg::OP_FIN_S: begin
        g_we = 1'b1; g_addr = {7'd1, 7'd1}; g_wd = rpmg_pkg::K_START;
      end
      rpmg_pkg::OP_FIN_G: begin
        g_we = 1'b1; g_addr = {gc, gr}; g_wd = rpmg_pkg::K_GOAL;
      end
      rpmg_pkg::OP_FIN_RL: begin
        g_re = 1'b1; g_addr = {gc - 7'd1, gr};
      end
      rpmg_pkg::OP_FIN_RU: begin
        g_re = 1'b1; g_addr = {gc, gr - 7'd1};
      end
      rpmg_pkg::OP_FIN_OPEN: begin
        g_we = left_wall_r && up_wall_r; g_addr = {gc - 7'd1, gr}; g_wd = rpmg_pkg::K_PASS;
      end
      rpmg_pkg::OP_CELL_RD: begin
        g_re = 1'b1; g_addr = {req_r.read_col, req_r.read_row};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (g_we) grid_mem[g_addr] <= g_wd;
    if (g_re) g_rd_r <= grid_mem[g_addr];
  end

  always_ff @(posedge clk) begin
    if (l_we) list_mem[l_waddr] <= l_wd;
    if (l_re) l_rd_r <= list_mem[l_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_cfg_r  <= rpmg_pkg::RST_COLS;
      rows_cfg_r  <= rpmg_pkg::RST_ROWS;
      act_cols_r  <= clampv(rpmg_pkg::RST_COLS, rpmg_pkg::MAX_COLS);
      act_rows_r  <= clampv(rpmg_pkg::RST_ROWS, rpmg_pkg::MAX_ROWS);
      clr_addr_r  <= '0;
      count_r     <= '0;
      phase_r     <= rpmg_pkg::PH_IDLE;
      nb_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == rpmg_pkg::CFG_COLS) cols_cfg_r <= cfg_data;
      if (cfg_we && cfg_index == rpmg_pkg::CFG_ROWS) rows_cfg_r <= cfg_data;
      if (cmd.op == rpmg_pkg::OP_OUT) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (cmd.op)
        rpmg_pkg::OP_LATCH: begin
          req_r <= in_data; pc_r <= '0; pr_r <= '0; opened_r <= 1'b0; kind_r <= rpmg_pkg::K_WALL;
        end
        rpmg_pkg::OP_CLR: clr_addr_r <= clr_addr_r + 14'd1;
        rpmg_pkg::OP_START_INIT: begin
          act_cols_r <= clampv(cols_cfg_r, rpmg_pkg::MAX_COLS);
          act_rows_r <= clampv(rows_cfg_r, rpmg_pkg::MAX_ROWS);
        end
        rpmg_pkg::OP_SEED: begin
          count_r <= 17'd2; phase_r <= rpmg_pkg::PH_GEN;
        end
        rpmg_pkg::OP_DIV_INIT: begin
          rem_r <= '0; dvd_r <= req_r.random_word; it_r <= '0;
        end
        rpmg_pkg::OP_DIV_STEP: begin
          rem_r <= div_d[rpmg_pkg::CNT_W] ? div_acc[rpmg_pkg::CNT_W-1:0] :
                   div_d[rpmg_pkg::CNT_W-1:0];
          dvd_r <= {dvd_r[rpmg_pkg::RND_W-2:0], 1'b0};
          it_r  <= it_r + 5'd1;
        end
        rpmg_pkg::OP_PICK: begin
          pc_r <= pick_c; pr_r <= pick_r;
          ptr_r <= rem_r[rpmg_pkg::LIST_AW-1:0];
          count_r <= count_r - 17'd1;
          nb_idx_r <= '0;
        end
        rpmg_pkg::OP_SH_WR: ptr_r <= ptr_r + 16'd1;
        rpmg_pkg::OP_NB_CAP: begin
          pass_f_r[nb_idx_r] <= nb_in[nb_idx_r] && g_rd_r == rpmg_pkg::K_PASS;
          wall_f_r[nb_idx_r] <= nb_in[nb_idx_r] && g_rd_r == rpmg_pkg::K_WALL;
          nb_idx_r <= nb_idx_r + 2'd1;
        end
        rpmg_pkg::OP_OPEN: begin
          opened_r <= 1'b1; nb_idx_r <= '0;
        end
        rpmg_pkg::OP_PUSH: begin
          if (wall_f_r[nb_idx_r] && list_room) count_r <= count_r + 17'd1;
          nb_idx_r <= nb_idx_r + 2'd1;
        end
        rpmg_pkg::OP_FIN_CL: left_wall_r <= g_rd_r == rpmg_pkg::K_WALL;
        rpmg_pkg::OP_FIN_CU: up_wall_r <= g_rd_r == rpmg_pkg::K_WALL;
        rpmg_pkg::OP_FIN_OPEN: phase_r <= rpmg_pkg::PH_DONE;
        rpmg_pkg::OP_CELL_CAP: kind_r <= read_in ? g_rd_r : rpmg_pkg::K_WALL;
        rpmg_pkg::OP_OUT: begin
          out_data_r.status        <= cmd.stat;
          out_data_r.pick_col      <= pc_r;
          out_data_r.pick_row      <= pr_r;
          out_data_r.opened        <= opened_r;
          out_data_r.pending_count <= count_r;
          out_data_r.cell_kind     <= kind_r;
          out_data_r.finished      <= phase_r == rpmg_pkg::PH_DONE;
        end
        default: ;
      endcase
    end
  end

  assign sts.func       = req_r.func;
  assign sts.clr_last   = &clr_addr_r;
  assign sts.div_last   = it_r == 5'(rpmg_pkg::RND_W - 1);
  assign sts.sh_more    = {1'b0, ptr_r} < count_r;
  assign sts.nb_last    = nb_idx_r == 2'd3;
  assign sts.open_ok    = $countones(pass_f_r) < 2;
  assign sts.count_zero = count_r == '0;
  assign sts.step_ok    = phase_r == rpmg_pkg::PH_GEN && count_r != '0;
  assign sts.out_free   = out_free;
  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;

  `RPMG_ASSERT_IMP(a_count_bound, 1'b1, count_r <= rpmg_pkg::CNT_W'(rpmg_pkg::LIST_DEPTH))
  `RPMG_ASSERT_IMP(a_no_overwrite, cmd.op == rpmg_pkg::OP_OUT, out_free)
  `RPMG_ASSERT_NXT(a_rem_range, cmd.op == rpmg_pkg::OP_DIV_STEP && sts.div_last,
                   rem_r < count_r)
  `RPMG_ASSERT_IMP(a_done_empty, phase_r == rpmg_pkg::PH_DONE, count_r == '0)
endmodule

[rtl/rpmg_controller.sv]
// Controller state machine that sequences the maze generator datapath.
`timescale 1ns / 1ps
module rpmg_controller (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rpmg_pkg::dp_sts_t sts,
  output rpmg_pkg::dp_cmd_t cmd
);
  typedef enum logic [4:0] {
    S_RCLR, S_IDLE, S_DECODE, S_CLR, S_INIT, S_SEED, S_DIV_INIT, S_DIV, S_LRD, S_PICK,
    S_SH_CHK, S_SH_RD, S_SH_WR, S_NB_RD, S_NB_CAP, S_NB_DEC, S_OPEN, S_PUSH, S_STEP_END,
    S_FS, S_FG, S_FRL, S_FCL, S_FRU, S_FCU, S_FOPEN, S_CELL_RD, S_CELL_CAP, S_OUT
  } state_t;

  state_t     state_r;
  logic [2:0] stat_r;
  rpmg_pkg::dp_op_t op;

  always_comb begin
    unique case (state_r)
      S_RCLR, S_CLR: op = rpmg_pkg::OP_CLR;
      S_IDLE:        op = in_valid ? rpmg_pkg::OP_LATCH : rpmg_pkg::OP_NONE;
      S_INIT:        op = rpmg_pkg::OP_START_INIT;
      S_SEED:        op = rpmg_pkg::OP_SEED;
      S_DIV_INIT:    op = rpmg_pkg::OP_DIV_INIT;
      S_DIV:         op = rpmg_pkg::OP_DIV_STEP;
      S_LRD:         op = rpmg_pkg::OP_LIST_RD;
      S_PICK:        op = rpmg_pkg::OP_PICK;
      S_SH_RD:       op = rpmg_pkg::OP_SH_RD;
      S_SH_WR:       op = rpmg_pkg::OP_SH_WR;
      S_NB_RD:       op = rpmg_pkg::OP_NB_RD;
      S_NB_CAP:      op = rpmg_pkg::OP_NB_CAP;
      S_OPEN:        op = rpmg_pkg::OP_OPEN;
      S_PUSH:        op = rpmg_pkg::OP_PUSH;
      S_FS:          op = rpmg_pkg::OP_FIN_S;
      S_FG:          op = rpmg_pkg::OP_FIN_G;
      S_FRL:         op = rpmg_pkg::OP_FIN_RL;
      S_FCL:         op = rpmg_pkg::OP_FIN_CL;
      S_FRU:         op = rpmg_pkg::OP_FIN_RU;
      S_FCU:         op = rpmg_pkg::OP_FIN_CU;
      S_FOPEN:       op = rpmg_pkg::OP_FIN_OPEN;
      S_CELL_RD:     op = rpmg_pkg::OP_CELL_RD;
      S_CELL_CAP:    op = rpmg_pkg::OP_CELL_CAP;
      S_OUT:         op = sts.out_free ? rpmg_pkg::OP_OUT : rpmg_pkg::OP_NONE;
      default:       op = rpmg_pkg::OP_NONE;
    endcase
  end

  assign cmd.op   = op;
  assign cmd.stat = stat_r;
  assign in_ready = state_r == S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RCLR;
      stat_r  <= rpmg_pkg::ST_IGNORED;
    end else begin
      unique case (state_r)
        S_RCLR:     if (sts.clr_last) state_r <= S_IDLE;
        S_IDLE:     if (in_valid) state_r <= S_DECODE;
        S_DECODE: begin
          priority if (sts.func == rpmg_pkg::F_START) begin
            state_r <= S_CLR;
          end else if (sts.func == rpmg_pkg::F_STEP && sts.step_ok) begin
            state_r <= S_DIV_INIT;
          end else if (sts.func == rpmg_pkg::F_READ) begin
            state_r <= S_CELL_RD;
          end else begin
            stat_r <= rpmg_pkg::ST_IGNORED; state_r <= S_OUT;
          end
        end
        S_CLR:      if (sts.clr_last) state_r <= S_INIT;
        S_INIT:     state_r <= S_SEED;
        S_SEED: begin
          stat_r <= rpmg_pkg::ST_STARTED; state_r <= S_OUT;
        end
        S_DIV_INIT: state_r <= S_DIV;
        S_DIV:      if (sts.div_last) state_r <= S_LRD;
        S_LRD:      state_r <= S_PICK;
        S_PICK:     state_r <= S_SH_CHK;
        S_SH_CHK:   state_r <= sts.sh_more ? S_SH_RD : S_NB_RD;
        S_SH_RD:    state_r <= S_SH_WR;
        S_SH_WR:    state_r <= S_SH_CHK;
        S_NB_RD:    state_r <= S_NB_CAP;
        S_NB_CAP:   state_r <= sts.nb_last ? S_NB_DEC : S_NB_RD;
        S_NB_DEC:   state_r <= sts.open_ok ? S_OPEN : S_STEP_END;
        S_OPEN:     state_r <= S_PUSH;
        S_PUSH:     if (sts.nb_last) state_r <= S_STEP_END;
        S_STEP_END: begin
          if (sts.count_zero) begin
            state_r <= S_FS;
          end else begin
            stat_r <= rpmg_pkg::ST_STEPPED; state_r <= S_OUT;
          end
        end
        S_FS:       state_r <= S_FG;
        S_FG:       state_r <= S_FRL;
        S_FRL:      state_r <= S_FCL;
        S_FCL:      state_r <= S_FRU;
        S_FRU:      state_r <= S_FCU;
        S_FCU:      state_r <= S_FOPEN;
        S_FOPEN: begin
          stat_r <= rpmg_pkg::ST_FINISHED; state_r <= S_OUT;
        end
        S_CELL_RD:  state_r <= S_CELL_CAP;
        S_CELL_CAP: begin
          stat_r <= rpmg_pkg::ST_READ; state_r <= S_OUT;
        end
        S_OUT:      if (sts.out_free) state_r <= S_IDLE;
        default:    state_r <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/randomized_prim_maze_generator_unit.sv]
// A start refills every grid cell with walls, then latches the grid size and seeds the list.
// A step picks a wall list entry and shifts the later entries down; it opens the cell when
// allowed, pushing its wall neighbours; the step that empties the list completes the maze.
// One request is in work at a time; the next is taken the cycle after the response is set.
// After reset a clearing pass fills all 16384 grid cells before requests are taken.
// Configuration is taken at once; the latched grid size changes at the next start.
`timescale 1ns / 1ps
module randomized_prim_maze_generator_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  rpmg_pkg::in_req_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output rpmg_pkg::out_rsp_t             out_data,
  input  logic                           cfg_we,
  input  logic [rpmg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rpmg_pkg::DIM_W-1:0]     cfg_data
);
  rpmg_pkg::dp_cmd_t cmd;
  rpmg_pkg::dp_sts_t sts;

  rpmg_controller u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  rpmg_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_data(in_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );
endmodule

[tb/sv/randomized_prim_maze_generator_unit_checker.sv]
// Checker that predicts maze generator responses and compares them with the block.
`timescale 1ns / 1ps
module randomized_prim_maze_generator_unit_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  rpmg_pkg::in_req_t              in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  rpmg_pkg::out_rsp_t             out_data,
  input  logic                           cfg_we,
  input  logic [rpmg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rpmg_pkg::DIM_W-1:0]     cfg_data,
  output int                             fail_count,
  output int                             pending,
  output int                             resp_count,
  output int                             mazes_done
);

  logic [1:0]                   maze [0:16383];
  logic [rpmg_pkg::CELL_AW-1:0] frontier [$];
  logic [1:0]                   phase;
  logic [rpmg_pkg::DIM_W-1:0]   reg_cols, reg_rows;
  int                           span_c, span_r;
  rpmg_pkg::out_rsp_t           awaited [$];

  function automatic int clamp_dim(logic [rpmg_pkg::DIM_W-1:0] v,
                                   logic [rpmg_pkg::DIM_W-1:0] hi);
    if (v < rpmg_pkg::MIN_DIM) return rpmg_pkg::MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit is_inner(int v, int n);
    return v >= 1 && v + 2 <= n;
  endfunction

  task automatic wipe_maze();
    for (int i = 0; i < 16384; i++) maze[i] = rpmg_pkg::K_WALL;
  endtask

  task automatic add_frontier(int c, int r);
    if (frontier.size() < rpmg_pkg::LIST_DEPTH)
      frontier.insert(frontier.size(), {c[rpmg_pkg::COL_W-1:0], r[rpmg_pkg::ROW_W-1:0]});
  endtask

  task automatic advance_maze(input rpmg_pkg::in_req_t rq, output rpmg_pkg::out_rsp_t rs);
    int idx, c, r, around, nc, nr, gc, gr, left;
    int dc[4];
    int dr[4];
    dc = '{-1, 1, 0, 0};
    dr = '{0, 0, -1, 1};
    rs = '0;
    rs.status = rpmg_pkg::ST_IGNORED;
    if (rq.func == rpmg_pkg::F_START) begin
      span_c = clamp_dim(reg_cols, rpmg_pkg::MAX_COLS);
      span_r = clamp_dim(reg_rows, rpmg_pkg::MAX_ROWS);
      wipe_maze();
      maze[1 * 128 + 1] = rpmg_pkg::K_PASS;
      frontier.delete();
      add_frontier(1, 2);
      add_frontier(2, 1);
      phase = rpmg_pkg::PH_GEN;
      rs.status = rpmg_pkg::ST_STARTED;
    end else if (rq.func == rpmg_pkg::F_STEP && phase == rpmg_pkg::PH_GEN &&
                 frontier.size() > 0) begin
      idx = rq.random_word % frontier.size();
      c = frontier[idx][rpmg_pkg::CELL_AW-1:rpmg_pkg::ROW_W];
      r = frontier[idx][rpmg_pkg::ROW_W-1:0];
      frontier.delete(idx);
      if (c >= span_c) c = span_c - 1;
      if (r >= span_r) r = span_r - 1;
      rs.pick_col = c[rpmg_pkg::COL_W-1:0];
      rs.pick_row = r[rpmg_pkg::ROW_W-1:0];
      around = 0;
      for (int d = 0; d < 4; d++) begin
        nc = c + dc[d];
        nr = r + dr[d];
        if (is_inner(nc, span_c) && is_inner(nr, span_r) &&
            maze[nc * 128 + nr] == rpmg_pkg::K_PASS)
          around++;
      end
      if (around < 2) begin
        maze[c * 128 + r] = rpmg_pkg::K_PASS;
        rs.opened = 1'b1;
        for (int d = 0; d < 4; d++) begin
          nc = c + dc[d];
          nr = r + dr[d];
          if (is_inner(nc, span_c) && is_inner(nr, span_r) &&
              maze[nc * 128 + nr] == rpmg_pkg::K_WALL)
            add_frontier(nc, nr);
        end
      end
      rs.status = rpmg_pkg::ST_STEPPED;
      if (frontier.size() == 0) begin
        gc = span_c - 2;
        gr = span_r - 2;
        maze[1 * 128 + 1] = rpmg_pkg::K_START;
        maze[gc * 128 + gr] = rpmg_pkg::K_GOAL;
        if (maze[(gc - 1) * 128 + gr] == rpmg_pkg::K_WALL &&
            maze[gc * 128 + gr - 1] == rpmg_pkg::K_WALL)
          maze[(gc - 1) * 128 + gr] = rpmg_pkg::K_PASS;
        phase = rpmg_pkg::PH_DONE;
        rs.status = rpmg_pkg::ST_FINISHED;
      end
    end else if (rq.func == rpmg_pkg::F_READ) begin
      rs.status = rpmg_pkg::ST_READ;
      if (rq.read_col < span_c && rq.read_row < span_r)
        rs.cell_kind = maze[rq.read_col * 128 + rq.read_row];
    end
    left = frontier.size();
    rs.pending_count = left[rpmg_pkg::CNT_W-1:0];
    rs.finished = (phase == rpmg_pkg::PH_DONE);
  endtask

  always @(posedge clk) begin
    rpmg_pkg::out_rsp_t want, got;
    if (!rst_n) begin
      wipe_maze();
      frontier.delete();
      awaited.delete();
      phase = rpmg_pkg::PH_IDLE;
      reg_cols = rpmg_pkg::RST_COLS;
      reg_rows = rpmg_pkg::RST_ROWS;
      span_c = clamp_dim(rpmg_pkg::RST_COLS, rpmg_pkg::MAX_COLS);
      span_r = clamp_dim(rpmg_pkg::RST_ROWS, rpmg_pkg::MAX_ROWS);
      fail_count = 0;
      resp_count = 0;
      mazes_done = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == rpmg_pkg::CFG_COLS) reg_cols = cfg_data;
        else reg_rows = cfg_data;
      end
      if (in_valid && in_ready) begin
        advance_maze(in_data, want);
        awaited.insert(awaited.size(), want);
      end
      if (out_valid && out_ready) begin
        got = out_data;
        resp_count++;
        if (awaited.size() == 0) begin
          $error("response with no request outstanding: %p", got);
          fail_count++;
        end else begin
          want = awaited.pop_front();
          if (want.status == rpmg_pkg::ST_FINISHED) mazes_done++;
          if (got.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.pick_col !== want.pick_col) begin
            $error("pick_col expected %0d got %0d", want.pick_col, got.pick_col);
            fail_count++;
          end
          if (got.pick_row !== want.pick_row) begin
            $error("pick_row expected %0d got %0d", want.pick_row, got.pick_row);
            fail_count++;
          end
          if (got.opened !== want.opened) begin
            $error("opened expected %0d got %0d", want.opened, got.opened);
            fail_count++;
          end
          if (got.pending_count !== want.pending_count) begin
            $error("pending_count expected %0d got %0d", want.pending_count,
                   got.pending_count);
            fail_count++;
          end
          if (got.cell_kind !== want.cell_kind) begin
            $error("cell_kind expected %0d got %0d", want.cell_kind, got.cell_kind);
            fail_count++;
          end
          if (got.finished !== want.finished) begin
            $error("finished expected %0d got %0d", want.finished, got.finished);
            fail_count++;
          end
        end
      end
    end
    pending = awaited.size();
  end

endmodule

[tb/sv/randomized_prim_maze_generator_unit_test.sv]
// Top of the maze generator testbench: clock, reset, requests and verdict.
`timescale 1ns / 1ps
module randomized_prim_maze_generator_unit_test;
  localparam logic [1:0] F_SPARE = 2'd3;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  rpmg_pkg::in_req_t              in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  rpmg_pkg::out_rsp_t             out_data;
  logic                           cfg_we = 1'b0;
  logic [rpmg_pkg::CFG_IDX_W-1:0] cfg_index = rpmg_pkg::CFG_COLS;
  logic [rpmg_pkg::DIM_W-1:0]     cfg_data = '0;
  int                             fail_count, pending, resp_count, mazes_done;
  int                             sent = 0;
  int                             cur_cols = rpmg_pkg::RST_COLS;
  int                             cur_rows = rpmg_pkg::RST_ROWS;
  int                             size_c, size_r;
  bit                             quiet = 1'b0;

  always #4 clk = ~clk;

  randomized_prim_maze_generator_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  randomized_prim_maze_generator_unit_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending),
    .resp_count(resp_count), .mazes_done(mazes_done)
  );

  task automatic send(logic [1:0] f, logic [rpmg_pkg::RND_W-1:0] w, int c, int r);
    rpmg_pkg::in_req_t rq;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    rq.func = f;
    rq.random_word = w;
    rq.read_col = c[rpmg_pkg::COL_W-1:0];
    rq.read_row = r[rpmg_pkg::ROW_W-1:0];
    in_valid <= 1'b1;
    in_data <= rq;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (!in_ready || out_valid || pending != 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_size(logic [rpmg_pkg::DIM_W-1:0] c, logic [rpmg_pkg::DIM_W-1:0] r);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= rpmg_pkg::CFG_COLS;
    cfg_data <= c;
    @(posedge clk);
    cfg_index <= rpmg_pkg::CFG_ROWS;
    cfg_data <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_cols = (c < rpmg_pkg::MIN_DIM) ? rpmg_pkg::MIN_DIM :
               (c > rpmg_pkg::MAX_COLS) ? rpmg_pkg::MAX_COLS : c;
    cur_rows = (r < rpmg_pkg::MIN_DIM) ? rpmg_pkg::MIN_DIM :
               (r > rpmg_pkg::MAX_ROWS) ? rpmg_pkg::MAX_ROWS : r;
  endtask

  task automatic random_request();
    int pick;
    logic [31:0] w;
    pick = $urandom_range(0, 99);
    w = $urandom;
    if (pick < 66)
      send(rpmg_pkg::F_STEP, w[rpmg_pkg::RND_W-1:0], 0, 0);
    else if (pick < 88) begin
      if ($urandom_range(0, 3) == 0)
        send(rpmg_pkg::F_READ, w[rpmg_pkg::RND_W-1:0], $urandom_range(0, 127),
             $urandom_range(0, 127));
      else
        send(rpmg_pkg::F_READ, w[rpmg_pkg::RND_W-1:0], $urandom_range(0, cur_cols),
             $urandom_range(0, cur_rows));
    end else if (pick < 95)
      send(rpmg_pkg::F_START, w[rpmg_pkg::RND_W-1:0], $urandom_range(0, 127),
           $urandom_range(0, 127));
    else
      send(F_SPARE, w[rpmg_pkg::RND_W-1:0], $urandom_range(0, 127), $urandom_range(0, 127));
  endtask

  initial begin
    forever begin
      if (quiet || $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
  end

  initial begin
    #200ms;
    $display("randomized_prim_maze_generator_unit_test NOT OK");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(rpmg_pkg::F_STEP, 31'h7FFFFFFF, 0, 0);
    send(F_SPARE, 31'h0, 127, 127);
    send(rpmg_pkg::F_READ, 31'h0, 0, 0);
    send(rpmg_pkg::F_START, 31'h0, 0, 0);
    send(rpmg_pkg::F_READ, 31'h0, 1, 1);
    send(rpmg_pkg::F_STEP, 31'h0, 0, 0);
    send(rpmg_pkg::F_STEP, 31'h7FFFFFFF, 0, 0);
    send(rpmg_pkg::F_READ, 31'h7FFFFFFF, 127, 127);
    send(rpmg_pkg::F_READ, 31'h0, 79, 44);

    set_size(8'd5, 8'd5);
    send(rpmg_pkg::F_START, 31'h0, 0, 0);
    repeat (6) send(rpmg_pkg::F_STEP, $urandom_range(0, 32'h7FFFFFFF), 0, 0);
    send(rpmg_pkg::F_READ, 31'h0, 3, 3);
    send(rpmg_pkg::F_READ, 31'h0, 1, 1);
    send(rpmg_pkg::F_READ, 31'h0, 2, 3);
    send(rpmg_pkg::F_STEP, 31'h0, 0, 0);

    set_size(8'd0, 8'd255);
    send(rpmg_pkg::F_START, 31'h0, 0, 0);
    send(rpmg_pkg::F_STEP, 31'h1, 0, 0);
    send(rpmg_pkg::F_READ, 31'h0, 4, 127);

    for (int ph = 0; ph < 4; ph++) begin
      size_c = $urandom_range(5, 11);
      size_r = $urandom_range(5, 11);
      if (ph == 1) set_size(8'd128, 8'd6);
      else set_size(size_c[rpmg_pkg::DIM_W-1:0], size_r[rpmg_pkg::DIM_W-1:0]);
      if (ph == 3) quiet = 1'b1;
      send(rpmg_pkg::F_START, $urandom_range(0, 32'h7FFFFFFF), 0, 0);
      for (int k = 0; k < 66; k++) begin
        if (ph == 0 && k == 30) drain();
        random_request();
      end
    end

    drain();
    repeat (40) @(posedge clk);
    $display("Sent %0d requests and checked %0d responses.", sent, resp_count);
    $display("Mazes completed: %0d, over several grid sizes including clamped ones.",
             mazes_done);
    if (fail_count == 0) begin
      $display("randomized_prim_maze_generator_unit_test OK");
    end else begin
      $display("randomized_prim_maze_generator_unit_test NOT OK");
    end
    $finish;
  end

endmodule
